/* sv/assert_macros.svh */
// Assertion macros shared by the spectrum unpack modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* sv/pssb_pkg.sv */
// Package with types, constants and register codes of the spectrum unpacker.
`timescale 1ns / 1ps

package pssb_pkg;

	// Field widths of the ports.
	localparam int BYTE_W   = 8;
	localparam int SAMPLE_W = 12;
	localparam int COEF_W   = 32;
	localparam int BW_W     = 7;
	localparam int FIRST_W  = 12;
	localparam int OUTCH_W  = 13;
	localparam int VALUE_W  = 48;
	localparam int CHAN_W   = 12;
	localparam int IDX_W    = 3;

	// Sizing defaults and limits.
	localparam int MAX_CHANNELS_DEF = 4096;
	localparam int MAX_BIN          = 64;
	localparam int FILL_W           = 7;
	localparam int FIFO_DEPTH       = 4;

	// Datapath widths of the scaling arithmetic.
	localparam int FRAC_W    = 16;
	localparam int A_W       = SAMPLE_W + 1 + COEF_W + 1;
	localparam int MAG_A_W   = 44;
	localparam int MAG_LO_W  = 22;
	localparam int MAG_HI_W  = MAG_A_W - MAG_LO_W;
	localparam int PART_W    = MAG_LO_W + COEF_W;
	localparam int FULL_W    = MAG_A_W + COEF_W;
	localparam int Q_W       = FULL_W - FRAC_W;
	localparam int SUM_W     = VALUE_W + $clog2(MAX_BIN);

	// Bin divider: two quotient bits per cycle.
	localparam int DIV_STEPS = 2;
	localparam int DIV_CYC   = SUM_W / DIV_STEPS;
	localparam int REM_W     = BW_W;

	// Register reset values.
	localparam logic signed [COEF_W-1:0] SCALE_RST  = 32'sd65536;
	localparam logic signed [COEF_W-1:0] OFFSET_RST = 32'sd0;
	localparam logic signed [COEF_W-1:0] GAIN_RST   = 32'sd65536;
	localparam logic [BW_W-1:0]          BW_RST     = 7'd1;
	localparam logic [FIRST_W-1:0]       FIRST_RST  = 12'd0;
	localparam logic [OUTCH_W-1:0]       OUTCH_RST  = 13'd4096;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_SCALE         = 3'd0,
		REG_OFFSET        = 3'd1,
		REG_GAIN          = 3'd2,
		REG_BIN_WIDTH     = 3'd3,
		REG_FIRST_CHANNEL = 3'd4,
		REG_OUT_CHANNELS  = 3'd5
	} reg_idx_t;

	// What the back end does with a token.
	typedef enum logic [1:0] {
		TK_NONE,
		TK_DIRECT,
		TK_ACC,
		TK_CLOSE
	} tok_kind_t;

	// Back end sequencer states.
	typedef enum logic [3:0] {
		B_IDLE,
		B_MUL,
		B_ABS,
		B_LO,
		B_HI,
		B_SUM,
		B_SAT,
		B_ACC,
		B_DIV,
		B_OUT
	} back_state_t;

	// Configuration register set.
	typedef struct packed {
		logic signed [COEF_W-1:0] scale;
		logic signed [COEF_W-1:0] offset;
		logic signed [COEF_W-1:0] gain;
		logic [BW_W-1:0]          bin_width;
		logic [FIRST_W-1:0]       first_channel;
		logic [OUTCH_W-1:0]       out_channels;
	} cfg_t;

	// One classified sample passed from front to back.
	typedef struct packed {
		tok_kind_t             kind;
		logic [SAMPLE_W-1:0]   sample;
		logic [CHAN_W-1:0]     chan;
		logic [BW_W-1:0]       w;
		logic                  fin;
		logic                  row_end;
	} tok_t;

endpackage

/* sv/pssb_front.sv */
// Front end: unpacks byte triplets into samples and classifies each one.
`timescale 1ns / 1ps

module pssb_front #(
	parameter int MAX_CHANNELS = pssb_pkg::MAX_CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pssb_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	input  logic [pssb_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          last_byte,
	output logic                          tok_valid,
	output pssb_pkg::tok_t                tok
);

	localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_HI    = 2'd1;
	localparam logic [1:0] PH_LO    = 2'd2;

	logic [1:0]                          phase_q;
	logic [1:0]                          phase_n;
	logic [pssb_pkg::BYTE_W-1:0]         held_q;
	logic [pssb_pkg::BYTE_W-1:0]         held_n;
	logic [CNT_W-1:0]                    raw_cnt_q;
	logic [pssb_pkg::FILL_W-1:0]         fill_q;
	logic [pssb_pkg::FILL_W-1:0]         fill_inc;
	logic [pssb_pkg::OUTCH_W-1:0]        out_cnt_q;
	logic [pssb_pkg::OUTCH_W-1:0]        out_inc;
	logic [pssb_pkg::BW_W-1:0]           w_eff;
	logic [pssb_pkg::OUTCH_W-1:0]        nout;
	logic [pssb_pkg::SAMPLE_W-1:0]       sample;
	logic                                have;
	logic                                in_range;
	logic                                binnable;
	pssb_pkg::tok_kind_t                 kind;

	// Sample extraction, effective bin width and classification.
	always_comb begin
		if (cfg.bin_width == '0) begin
			w_eff = pssb_pkg::BW_W'(1);
		end else if (32'(cfg.bin_width) > pssb_pkg::MAX_BIN) begin
			w_eff = pssb_pkg::BW_W'(pssb_pkg::MAX_BIN);
		end else begin
			w_eff = cfg.bin_width;
		end

		if (32'(cfg.out_channels) > MAX_CHANNELS) begin
			nout = pssb_pkg::OUTCH_W'(MAX_CHANNELS);
		end else begin
			nout = cfg.out_channels;
		end

		case (phase_q)
			PH_HI: begin
				sample  = {held_q, data_byte[7:4]};
				have    = 1'b1;
				held_n  = data_byte;
				phase_n = PH_LO;
			end
			PH_LO: begin
				sample  = {held_q[3:0], data_byte};
				have    = 1'b1;
				held_n  = '0;
				phase_n = PH_START;
			end
			default: begin
				sample  = '0;
				have    = 1'b0;
				held_n  = data_byte;
				phase_n = PH_HI;
			end
		endcase

		in_range = have && (raw_cnt_q < CNT_W'(MAX_CHANNELS));
		fill_inc = fill_q + pssb_pkg::FILL_W'(1);
		out_inc  = out_cnt_q + pssb_pkg::OUTCH_W'(1);
		binnable = (32'(raw_cnt_q) >= 32'(cfg.first_channel)) && (out_cnt_q < nout);

		if (!in_range) begin
			kind = pssb_pkg::TK_NONE;
		end else if (w_eff == pssb_pkg::BW_W'(1)) begin
			kind = pssb_pkg::TK_DIRECT;
		end else if (binnable) begin
			kind = (fill_inc >= w_eff) ? pssb_pkg::TK_CLOSE : pssb_pkg::TK_ACC;
		end else begin
			kind = pssb_pkg::TK_NONE;
		end

		// A partial group at the row end is dropped, so its sample needs no work.
		tok.kind    = (last_byte && kind == pssb_pkg::TK_ACC) ? pssb_pkg::TK_NONE : kind;
		tok.sample  = sample;
		tok.chan    = (kind == pssb_pkg::TK_CLOSE) ? out_cnt_q[pssb_pkg::CHAN_W-1:0]
			: pssb_pkg::CHAN_W'(raw_cnt_q);
		tok.w       = w_eff;
		tok.fin     = last_byte || (kind == pssb_pkg::TK_CLOSE && out_inc == nout);
		tok.row_end = last_byte;
		tok_valid   = in_valid && (tok.kind != pssb_pkg::TK_NONE || last_byte);
	end

	// Row state; a flagged last byte clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			held_q    <= '0;
			raw_cnt_q <= '0;
			fill_q    <= '0;
			out_cnt_q <= '0;
		end else if (in_valid) begin
			if (last_byte) begin
				phase_q   <= PH_START;
				held_q    <= '0;
				raw_cnt_q <= '0;
				fill_q    <= '0;
				out_cnt_q <= '0;
			end else begin
				phase_q <= phase_n;
				held_q  <= held_n;
				if (in_range) begin
					raw_cnt_q <= raw_cnt_q + CNT_W'(1);
				end
				if (kind == pssb_pkg::TK_ACC) begin
					fill_q <= fill_inc;
				end else if (kind == pssb_pkg::TK_CLOSE) begin
					fill_q    <= '0;
					out_cnt_q <= out_inc;
				end
			end
		end
	end

endmodule

/* sv/pssb_fifo.sv */
// Short token queue between the front end and the back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pssb_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  pssb_pkg::tok_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output pssb_pkg::tok_t rd_data,
	output logic           empty
);

	localparam int DEPTH = pssb_pkg::FIFO_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);

	pssb_pkg::tok_t     mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;

	assign full    = (count_q == (PTR_W + 1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Storage needs no reset; only the pointers do.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + (PTR_W + 1)'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - (PTR_W + 1)'(1);
			end
		end
	end

	`ASSERT_NEVER(fifo_overflow_a, clk, arst_n, wr_en && full, "token written into a full queue")
	`ASSERT_NEVER(fifo_underflow_a, clk, arst_n, rd_en && empty, "token read from an empty queue")

endmodule

/* sv/pssb_div.sv */
// Iterative signed divider for bin averages, truncating toward zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pssb_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [pssb_pkg::SUM_W-1:0]   dividend,
	input  logic [pssb_pkg::BW_W-1:0]           divisor,
	output logic                                busy,
	output logic                                done,
	output logic [pssb_pkg::VALUE_W-1:0]        quotient
);

	localparam int SUM_W = pssb_pkg::SUM_W;
	localparam int REM_W = pssb_pkg::REM_W;
	localparam int CYC_W = $clog2(pssb_pkg::DIV_CYC + 1);

	logic [SUM_W-1:0]          num_q;
	logic [SUM_W-1:0]          num_n;
	logic [SUM_W-1:0]          dvd_abs;
	logic [REM_W-1:0]          rem_q;
	logic [REM_W-1:0]          rem_n;
	logic [REM_W:0]            trial;
	logic [pssb_pkg::BW_W-1:0] den_q;
	logic                      neg_q;
	logic [CYC_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;

	// Restoring steps: each shifts in one dividend bit and yields one quotient bit.
	always_comb begin
		rem_n = rem_q;
		num_n = num_q;
		trial = '0;
		for (int i = 0; i < pssb_pkg::DIV_STEPS; i++) begin
			trial = {rem_n, num_n[SUM_W-1]};
			num_n = {num_n[SUM_W-2:0], 1'b0};
			if (trial >= (REM_W + 1)'(den_q)) begin
				trial    = trial - (REM_W + 1)'(den_q);
				num_n[0] = 1'b1;
			end
			rem_n = trial[REM_W-1:0];
		end
	end

	assign dvd_abs  = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
	assign quotient = neg_q ? (~num_q[pssb_pkg::VALUE_W-1:0] + pssb_pkg::VALUE_W'(1))
		: num_q[pssb_pkg::VALUE_W-1:0];
	assign busy     = busy_q;
	assign done     = done_q;

	// Operand registers.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dvd_abs;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q) begin
			num_q <= num_n;
			rem_q <= rem_n;
		end
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CYC_W'(pssb_pkg::DIV_CYC);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CYC_W'(1);
				if (cnt_q == CYC_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	`ASSERT_PROP(div_start_busy_a, clk, arst_n, start |=> busy, "divider did not start")

endmodule

/* sv/pssb_back.sv */
// Back end: scales each sample, accumulates bins and holds the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pssb_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pssb_pkg::cfg_t                      cfg,
	input  logic                                fifo_empty,
	input  pssb_pkg::tok_t                      tok,
	output logic                                fifo_rd,
	input  logic                                pop,
	output logic                                empty,
	output logic [pssb_pkg::VALUE_W-1:0]        value,
	output logic [pssb_pkg::CHAN_W-1:0]         channel,
	output logic                                last_result
);

	localparam int A_W     = pssb_pkg::A_W;
	localparam int Q_W     = pssb_pkg::Q_W;
	localparam int VALUE_W = pssb_pkg::VALUE_W;
	localparam int SUM_W   = pssb_pkg::SUM_W;
	localparam int LO_W    = pssb_pkg::MAG_LO_W;

	localparam logic [Q_W-1:0] POS_LIM = {{(Q_W - VALUE_W + 1){1'b0}}, {(VALUE_W - 1){1'b1}}};
	localparam logic [Q_W-1:0] NEG_LIM = POS_LIM + Q_W'(1);

	pssb_pkg::back_state_t             state_q;
	pssb_pkg::back_state_t             state_n;
	pssb_pkg::tok_t                    tok_q;
	logic signed [A_W-1:0]             a_q;
	logic signed [A_W-1:0]             a_next;
	logic [A_W-1:0]                    a_abs;
	logic [pssb_pkg::COEF_W-1:0]       g_abs;
	logic [pssb_pkg::MAG_A_W-1:0]      ma_q;
	logic [pssb_pkg::COEF_W-1:0]       mg_q;
	logic                              neg_q;
	logic [pssb_pkg::PART_W-1:0]       plo_q;
	logic [pssb_pkg::PART_W-1:0]       phi_q;
	logic [pssb_pkg::FULL_W-1:0]       full_prod;
	logic [Q_W-1:0]                    q_q;
	logic [VALUE_W-1:0]                v_pos;
	logic [VALUE_W-1:0]                v_nmag;
	logic signed [VALUE_W-1:0]         v_q;
	logic signed [SUM_W-1:0]           sum_q;
	logic signed [SUM_W-1:0]           sum_next;
	logic [VALUE_W-1:0]                res_q;
	logic                              out_valid_q;
	logic [VALUE_W-1:0]                out_value_q;
	logic [pssb_pkg::CHAN_W-1:0]       out_chan_q;
	logic                              out_last_q;
	logic                              out_load;
	logic                              div_start;
	logic                              div_busy;
	logic                              div_done;
	logic [VALUE_W-1:0]                div_quot;

	// Arithmetic between the sequencer registers.
	always_comb begin
		a_next    = A_W'($signed({1'b0, tok_q.sample}) * cfg.scale) + A_W'(cfg.offset);
		a_abs     = a_q[A_W-1] ? (~a_q + A_W'(1)) : a_q;
		g_abs     = cfg.gain[pssb_pkg::COEF_W-1] ? (~cfg.gain + pssb_pkg::COEF_W'(1)) : cfg.gain;
		full_prod = {phi_q, {LO_W{1'b0}}} + pssb_pkg::FULL_W'(plo_q);
		v_pos     = (q_q > POS_LIM) ? POS_LIM[VALUE_W-1:0] : q_q[VALUE_W-1:0];
		v_nmag    = (q_q > NEG_LIM) ? NEG_LIM[VALUE_W-1:0] : q_q[VALUE_W-1:0];
		sum_next  = sum_q + SUM_W'(v_q);
	end

	// Sequencer next state and handshakes.
	always_comb begin
		state_n   = state_q;
		fifo_rd   = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			pssb_pkg::B_IDLE: begin
				fifo_rd = !fifo_empty;
				if (!fifo_empty && tok.kind != pssb_pkg::TK_NONE) begin
					state_n = pssb_pkg::B_MUL;
				end
			end
			pssb_pkg::B_MUL: state_n = pssb_pkg::B_ABS;
			pssb_pkg::B_ABS: state_n = pssb_pkg::B_LO;
			pssb_pkg::B_LO:  state_n = pssb_pkg::B_HI;
			pssb_pkg::B_HI:  state_n = pssb_pkg::B_SUM;
			pssb_pkg::B_SUM: state_n = pssb_pkg::B_SAT;
			pssb_pkg::B_SAT: state_n = pssb_pkg::B_ACC;
			pssb_pkg::B_ACC: begin
				case (tok_q.kind)
					pssb_pkg::TK_DIRECT: state_n = pssb_pkg::B_OUT;
					pssb_pkg::TK_CLOSE: begin
						div_start = 1'b1;
						state_n   = pssb_pkg::B_DIV;
					end
					default: state_n = pssb_pkg::B_IDLE;
				endcase
			end
			pssb_pkg::B_DIV: begin
				if (div_done) begin
					state_n = pssb_pkg::B_OUT;
				end
			end
			pssb_pkg::B_OUT: begin
				out_load = !out_valid_q || pop;
				if (out_load) begin
					state_n = pssb_pkg::B_IDLE;
				end
			end
			default: state_n = pssb_pkg::B_IDLE;
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (fifo_rd) begin
			tok_q <= tok;
		end
		a_q   <= a_next;
		ma_q  <= a_abs[pssb_pkg::MAG_A_W-1:0];
		mg_q  <= g_abs;
		neg_q <= a_q[A_W-1] ^ cfg.gain[pssb_pkg::COEF_W-1];
		plo_q <= pssb_pkg::PART_W'(ma_q[LO_W-1:0] * mg_q);
		phi_q <= pssb_pkg::PART_W'(ma_q[pssb_pkg::MAG_A_W-1:LO_W] * mg_q);
		q_q   <= full_prod[pssb_pkg::FULL_W-1:pssb_pkg::FRAC_W];
		if (state_q == pssb_pkg::B_SAT) begin
			v_q <= neg_q ? (~v_nmag + VALUE_W'(1)) : v_pos;
		end
		if (state_q == pssb_pkg::B_ACC) begin
			res_q <= v_q;
		end else if (div_done) begin
			res_q <= div_quot;
		end
	end

	// Bin sum: cleared when a group closes and at the end of a row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pssb_pkg::B_IDLE;
			sum_q   <= '0;
		end else begin
			state_q <= state_n;
			if (fifo_rd && tok.kind == pssb_pkg::TK_NONE) begin
				sum_q <= '0;
			end else if (state_q == pssb_pkg::B_ACC && tok_q.kind == pssb_pkg::TK_ACC) begin
				sum_q <= sum_next;
			end else if (div_start || (out_load && tok_q.row_end)) begin
				sum_q <= '0;
			end
		end
	end

	// Result register: a finished result waits here until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= res_q;
			out_chan_q  <= tok_q.chan;
			out_last_q  <= tok_q.fin;
		end
	end

	assign empty       = !out_valid_q;
	assign value       = out_value_q;
	assign channel     = out_chan_q;
	assign last_result = out_last_q;

	pssb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  (tok_q.w),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	`ASSERT_NEVER(back_done_state_a, clk, arst_n, div_done && state_q != pssb_pkg::B_DIV, "divider finished outside the wait state")
	`ASSERT_NEVER(back_start_busy_a, clk, arst_n, div_start && div_busy, "divider restarted while busy")

endmodule

/* sv/packed_spectrum_unpack_scale_bin.sv */
// Top level of the packed 12-bit spectrum unpacker with scaling and binning.
`timescale 1ns / 1ps

// Bytes of a packed row enter through a queue-style push port, one byte per cycle
// while full is low; every three bytes carry two big-endian 12-bit samples. Each
// sample is scaled as ((sample * scale + offset) * gain) >> 16 and saturated to
// 48 bits; with a bin width above one, groups of samples from first_channel on
// are averaged and up to out_channels results are made. Results leave through a
// queue style pop port. The front end unpacks and classifies bytes, one per
// cycle while the queue has room, into a four-entry token queue. The back end
// sequencer takes one token at a time through its multiply, saturate and result
// stages built on two 22 x 32 bit partial products. A sample that closes a bin
// also waits for the two-bit-per-cycle divider. A result that is not taken holds
// the back end until the result register frees up. Configuration writes are
// always ready and are meant for times when no row is in flight.
module packed_spectrum_unpack_scale_bin #(
	parameter int MAX_CHANNELS = pssb_pkg::MAX_CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [pssb_pkg::BYTE_W-1:0]       data_byte,
	input  logic                              last_byte,
	output logic                              empty,
	input  logic                              pop,
	output logic [pssb_pkg::VALUE_W-1:0]      value,
	output logic [pssb_pkg::CHAN_W-1:0]       channel,
	output logic                              last_result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pssb_pkg::IDX_W-1:0]        cfg_index,
	input  logic [pssb_pkg::COEF_W-1:0]       cfg_data
);

	pssb_pkg::cfg_t cfg_q;
	pssb_pkg::tok_t front_tok;
	pssb_pkg::tok_t back_tok;
	logic           in_valid;
	logic           tok_valid;
	logic           fifo_empty;
	logic           fifo_rd;

	assign cfg_ready = 1'b1;
	assign in_valid  = push && !full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale         <= pssb_pkg::SCALE_RST;
			cfg_q.offset        <= pssb_pkg::OFFSET_RST;
			cfg_q.gain          <= pssb_pkg::GAIN_RST;
			cfg_q.bin_width     <= pssb_pkg::BW_RST;
			cfg_q.first_channel <= pssb_pkg::FIRST_RST;
			cfg_q.out_channels  <= pssb_pkg::OUTCH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pssb_pkg::REG_SCALE:         cfg_q.scale <= cfg_data;
				pssb_pkg::REG_OFFSET:        cfg_q.offset <= cfg_data;
				pssb_pkg::REG_GAIN:          cfg_q.gain <= cfg_data;
				pssb_pkg::REG_BIN_WIDTH:     cfg_q.bin_width <= cfg_data[pssb_pkg::BW_W-1:0];
				pssb_pkg::REG_FIRST_CHANNEL: cfg_q.first_channel <= cfg_data[pssb_pkg::FIRST_W-1:0];
				pssb_pkg::REG_OUT_CHANNELS:  cfg_q.out_channels <= cfg_data[pssb_pkg::OUTCH_W-1:0];
				default: ;
			endcase
		end
	end

	pssb_front #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.tok_valid (tok_valid),
		.tok       (front_tok)
	);

	pssb_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tok_valid),
		.wr_data (front_tok),
		.full    (full),
		.rd_en   (fifo_rd),
		.rd_data (back_tok),
		.empty   (fifo_empty)
	);

	pssb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.fifo_empty  (fifo_empty),
		.tok         (back_tok),
		.fifo_rd     (fifo_rd),
		.pop         (pop),
		.empty       (empty),
		.value       (value),
		.channel     (channel),
		.last_result (last_result)
	);

endmodule

/* tb/packed_spectrum_unpack_scale_bin_tb.sv */
// Self-checking testbench for the packed 12-bit spectrum unpacker with scaling and binning.
`timescale 1ns / 1ps

module packed_spectrum_unpack_scale_bin_tb;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 11;
	// Token queue, back end sequencer and the bin divider settle well inside this.
	localparam int SETTLE_CYCLES = 600;
	localparam int HOLD_CYCLES   = 3000;
	// Covers the long receiver hold-off and the settle pauses several times over.
	localparam int STALL_LIMIT   = 20000;
	localparam int RANDOM_BYTES  = 1250;
	localparam int IDLE_PCT      = 33;

	localparam logic [63:0] VALUE_MAX = 64'h0000_7FFF_FFFF_FFFF;

	typedef struct {
		logic [pssb_pkg::BYTE_W-1:0] data;
		logic                        last;
	} row_byte_t;

	typedef struct {
		logic [pssb_pkg::VALUE_W-1:0] value;
		logic [pssb_pkg::CHAN_W-1:0]  channel;
		logic                         last;
	} channel_result_t;

	// Block ports.
	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          push        = 1'b0;
	logic                          full;
	logic [pssb_pkg::BYTE_W-1:0]   data_byte   = '0;
	logic                          last_byte   = 1'b0;
	logic                          empty;
	logic                          pop         = 1'b0;
	logic [pssb_pkg::VALUE_W-1:0]  value;
	logic [pssb_pkg::CHAN_W-1:0]   channel;
	logic                          last_result;
	logic                          cfg_valid   = 1'b0;
	logic                          cfg_ready;
	logic [pssb_pkg::IDX_W-1:0]    cfg_index   = '0;
	logic [pssb_pkg::COEF_W-1:0]   cfg_data    = '0;

	// Bytes waiting to be sent and channel results waiting to come out.
	row_byte_t       row_bytes[$];
	channel_result_t due_channels[$];
	int unsigned     bytes_queued   = 0;
	int unsigned     bytes_accepted = 0;
	int unsigned     errors         = 0;
	int unsigned     src_idle_pct   = IDLE_PCT;
	int unsigned     sink_idle_pct  = IDLE_PCT;
	int unsigned     hold_req       = 0;
	int unsigned     hold_left      = 0;
	int unsigned     stall_cycles   = 0;

	// Register copies as the block should hold them.
	int          cfg_scale  = int'(pssb_pkg::SCALE_RST);
	int          cfg_offset = int'(pssb_pkg::OFFSET_RST);
	int          cfg_gain   = int'(pssb_pkg::GAIN_RST);
	int unsigned cfg_bin_w  = pssb_pkg::BW_RST;
	int unsigned cfg_first  = pssb_pkg::FIRST_RST;
	int unsigned cfg_out_ch = pssb_pkg::OUTCH_RST;

	// Row state of the unpacker.
	logic [1:0]  phase    = 2'd0;
	logic [7:0]  held     = 8'd0;
	int unsigned raw_cnt  = 0;
	longint      bin_acc  = 0;
	int unsigned bin_cnt  = 0;
	int unsigned bins_out = 0;

	packed_spectrum_unpack_scale_bin i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.empty       (empty),
		.pop         (pop),
		.value       (value),
		.channel     (channel),
		.last_result (last_result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// (a * g) >> 16 on magnitudes, sign restored, saturated to 48 signed bits.
	function automatic longint scale_gain_q16(input longint a, input int g);
		logic [63:0] ma;
		logic [63:0] mg;
		logic [63:0] q;
		logic        neg;
		ma  = (a < 0) ? 64'(-a) : 64'(a);
		mg  = (g < 0) ? 64'(-longint'(g)) : 64'(longint'(g));
		neg = (a < 0) != (g < 0);
		q   = (ma >> 16) * mg + (((ma & 64'hFFFF) * mg) >> 16);
		if (!neg) begin
			if (q > VALUE_MAX)
				q = VALUE_MAX;
			return longint'(q);
		end
		if (q > VALUE_MAX + 64'd1)
			q = VALUE_MAX + 64'd1;
		return -longint'(q);
	endfunction

	// Advances the row state by one byte and queues the channel result it makes.
	task automatic unpack_byte(input logic [7:0] b, input logic last);
		logic            have;
		logic [11:0]     smp;
		int unsigned     grp;
		int unsigned     nout;
		int unsigned     idx;
		longint          acc;
		longint          v;
		longint          avg;
		channel_result_t r;
		have = 1'b0;
		smp  = '0;
		case (phase)
			2'd1: begin
				smp   = {held, b[7:4]};
				held  = b;
				phase = 2'd2;
				have  = 1'b1;
			end
			2'd2: begin
				smp   = {held[3:0], b};
				held  = '0;
				phase = 2'd0;
				have  = 1'b1;
			end
			default: begin
				held  = b;
				phase = 2'd1;
			end
		endcase
		// Samples past the channel limit of a row are dropped.
		if (have && raw_cnt < pssb_pkg::MAX_CHANNELS_DEF) begin
			idx  = raw_cnt;
			grp  = (cfg_bin_w == 0) ? 1
				: ((cfg_bin_w > pssb_pkg::MAX_BIN) ? pssb_pkg::MAX_BIN : cfg_bin_w);
			nout = (cfg_out_ch > pssb_pkg::MAX_CHANNELS_DEF) ? pssb_pkg::MAX_CHANNELS_DEF
				: cfg_out_ch;
			acc  = longint'(smp) * longint'(cfg_scale) + longint'(cfg_offset);
			v    = scale_gain_q16(acc, cfg_gain);
			raw_cnt++;
			if (grp == 1) begin
				r.value   = 48'(v);
				r.channel = 12'(idx);
				r.last    = last;
				due_channels.insert(due_channels.size(), r);
			end else if (idx >= cfg_first && bins_out < nout) begin
				bin_acc += v;
				bin_cnt++;
				if (bin_cnt >= grp) begin
					avg       = bin_acc / longint'(grp);
					r.value   = 48'(avg);
					r.channel = 12'(bins_out);
					r.last    = (bins_out + 1 == nout) || last;
					due_channels.insert(due_channels.size(), r);
					bins_out++;
					bin_acc = 0;
					bin_cnt = 0;
				end
			end
		end
		// A row end clears the row state but keeps the registers.
		if (last) begin
			phase    = 2'd0;
			held     = '0;
			raw_cnt  = 0;
			bin_acc  = 0;
			bin_cnt  = 0;
			bins_out = 0;
		end
	endtask

	// Byte driver: presents the oldest pending byte, holds it until the transfer.
	always @(posedge clk) begin
		logic next_push;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			next_push = push;
			if (push && !full) begin
				unpack_byte(data_byte, last_byte);
				void'(row_bytes.pop_front());
				bytes_accepted++;
				next_push = 1'b0;
			end
			if (!next_push && row_bytes.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
				next_push = 1'b1;
				data_byte <= row_bytes[0].data;
				last_byte <= row_bytes[0].last;
			end
			push <= next_push;
		end
	end

	// Result monitor: checks each transfer against the oldest due result.
	always @(posedge clk) begin
		channel_result_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (due_channels.size() == 0) begin
					$display("%0t: unexpected result: value %h channel %0d last %b",
						$time, value, channel, last_result);
					errors++;
				end else begin
					want = due_channels.pop_front();
					if (value !== want.value) begin
						$display("%0t: value on channel %0d: expected %h, actual %h",
							$time, want.channel, want.value, value);
						errors++;
					end
					if (channel !== want.channel) begin
						$display("%0t: channel: expected %0d, actual %0d",
							$time, want.channel, channel);
						errors++;
					end
					if (last_result !== want.last) begin
						$display("%0t: last mark on channel %0d: expected %b, actual %b",
							$time, want.channel, want.last, last_result);
						errors++;
					end
				end
			end
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99, 0) >= sink_idle_pct);
			end
		end
	end

	// Watchdog: ends the run when no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic last);
		row_byte_t rb;
		rb.data = b;
		rb.last = last;
		row_bytes.insert(row_bytes.size(), rb);
		bytes_queued++;
	endtask

	task automatic queue_row(input int unsigned nbytes, input logic close);
		for (int unsigned i = 0; i < nbytes; i++)
			queue_byte(8'($urandom_range(255, 0)), close && (i == nbytes - 1));
	endtask

	// Waits until every byte is sent and every result is back, then lets the block go quiet.
	task automatic settle();
		while (bytes_accepted != bytes_queued || due_channels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input pssb_pkg::reg_idx_t idx, input logic [31:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		case (idx)
			pssb_pkg::REG_SCALE:         cfg_scale  = int'(d);
			pssb_pkg::REG_OFFSET:        cfg_offset = int'(d);
			pssb_pkg::REG_GAIN:          cfg_gain   = int'(d);
			pssb_pkg::REG_BIN_WIDTH:     cfg_bin_w  = d[6:0];
			pssb_pkg::REG_FIRST_CHANNEL: cfg_first  = d[11:0];
			pssb_pkg::REG_OUT_CHANNELS:  cfg_out_ch = d[12:0];
			default: ;
		endcase
	endtask

	// Writes the whole register set once the block is idle.
	task automatic set_config(input logic [31:0] scl, input logic [31:0] ofs,
			input logic [31:0] gn, input logic [31:0] bw, input logic [31:0] first,
			input logic [31:0] nout);
		settle();
		write_reg(pssb_pkg::REG_SCALE, scl);
		write_reg(pssb_pkg::REG_OFFSET, ofs);
		write_reg(pssb_pkg::REG_GAIN, gn);
		write_reg(pssb_pkg::REG_BIN_WIDTH, bw);
		write_reg(pssb_pkg::REG_FIRST_CHANNEL, first);
		write_reg(pssb_pkg::REG_OUT_CHANNELS, nout);
	endtask

	// Coefficients: extremes, zero, full-range random and values near unity.
	function automatic logic [31:0] pick_coef();
		case ($urandom_range(7, 0))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3, 4: return $urandom;
			default: return 32'($urandom_range(196608, 0)) - 32'd65536;
		endcase
	endfunction

	initial begin
		int unsigned r;
		int unsigned w;
		int unsigned first;
		int unsigned nout;
		int unsigned weff;
		int unsigned neff;
		int unsigned n;
		int unsigned rows;
		int unsigned kind;
		int unsigned start;
		logic        fin_row;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: full-scale samples, zeros, a row ending on the middle byte
		// of a triplet, then a row ending on the first byte with nothing marked.
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h08, 1'b1);
		queue_byte(8'h5A, 1'b1);

		// Positive saturation.
		set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'd4096);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b1);

		// Negative saturation on a full sample, a large positive value on a zero sample.
		set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd0, 32'd4096);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hF0, 1'b0);
		queue_byte(8'h00, 1'b1);

		// Zero scale and offset give zero whatever the gain.
		set_config(32'h0, 32'h0, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'd4096);
		queue_row(3, 1'b1);

		// Pairs from channel one on with a negative odd sum: the average truncates
		// toward zero, and samples after the single output are ignored.
		set_config(32'd65537, 32'hFF9C_0000, 32'd65536, 32'd2, 32'd1, 32'd1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h10, 1'b0);
		queue_byte(8'h02, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h30, 1'b0);
		queue_byte(8'h04, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b1);

		// Random phases: a fresh register set each, then mostly well-formed rows.
		start = bytes_queued;
		for (int p = 0; bytes_queued - start < RANDOM_BYTES; p++) begin
			if (p == 0) begin
				// Receiver holds off while the sender keeps offering bytes.
				set_config(pick_coef(), pick_coef(), pick_coef(), 32'd1, 32'd0, 32'd4096);
				hold_req = HOLD_CYCLES;
				queue_row(120, 1'b1);
				continue;
			end
			r = $urandom_range(9, 0);
			if (r < 3)
				w = 1;
			else if (r < 8)
				w = $urandom_range(8, 2);
			else if (r == 8)
				w = pssb_pkg::MAX_BIN;
			else
				w = $urandom_range(1, 0) ? 0 : $urandom_range(127, pssb_pkg::MAX_BIN + 1);
			first = ($urandom_range(3, 0) == 0) ? $urandom_range(12, 1) : 0;
			r = $urandom_range(9, 0);
			if (r == 0)
				nout = 0;
			else if (r == 1)
				nout = $urandom_range(8191, 4096);
			else
				nout = $urandom_range(6, 1);
			set_config(pick_coef(), pick_coef(), pick_coef(), w, first, nout);
			// One phase runs with no idling on either side.
			src_idle_pct  = (p == 1) ? 0 : IDLE_PCT;
			sink_idle_pct = (p == 1) ? 0 : IDLE_PCT;
			weff = (w == 0) ? 1 : ((w > pssb_pkg::MAX_BIN) ? pssb_pkg::MAX_BIN : w);
			neff = (nout > 5) ? 5 : nout;
			rows = $urandom_range(5, 3);
			for (int unsigned k = 0; k < rows; k++) begin
				// The last row of a phase is closed, early once the byte budget is spent.
				fin_row = (k == rows - 1) || (bytes_queued - start >= RANDOM_BYTES);
				kind = fin_row ? 0 : $urandom_range(9, 0);
				if (kind < 7) begin
					if (weff == 1)
						n = $urandom_range(24, 1);
					else
						n = first + weff * neff + $urandom_range(3, 0);
					// Some rows stop early and leave a partial group.
					if (n > 1 && $urandom_range(3, 0) == 0)
						n = n - $urandom_range(n - 1, 1);
					if (n > 200)
						n = 200;
					if (n == 0)
						n = 1;
					queue_row(3 * ((n + 1) / 2), 1'b1);
				end else if (kind == 7) begin
					queue_row($urandom_range(30, 1), 1'b1);
				end else if (kind == 8) begin
					queue_row($urandom_range(20, 1), 1'b0);
				end else begin
					queue_row(1, 1'b1);
				end
				if (fin_row)
					break;
			end
		end

		settle();
		if (errors == 0 && due_channels.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
